@@ rtl/i2cr_pkg.sv @@
package i2cr_pkg;

  localparam int FILO_WORDS = 4;
  localparam int BYTES_W    = 6;
  localparam logic [BYTES_W-1:0] READ_BYTES = BYTES_W'(2 * FILO_WORDS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STOP1,
    PH_SSEL,
    PH_WA,
    PH_DELAY,
    PH_WP,
    PH_RSTART,
    PH_WR,
    PH_RD,
    PH_STOP2
  } phase_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pin_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] read_mask;
    logic [3:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    pin_t        pins;
    logic        word_valid;
    logic [15:0] word_value;
    logic        word_last;
    logic        done_res;
    logic        status;
    logic        busy_res;
  } res_t;

endpackage

@@ rtl/i2cr_core.sv @@
module i2cr_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          req_type,
  input  logic          sda_in,
  input  i2cr_pkg::cfg_t cfg,
  output i2cr_pkg::res_t res
);
  import i2cr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [3:0]          bit_cnt_r, bit_cnt_nxt;
  logic [BYTES_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [3:0]          attempts_r, attempts_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [7:0]          high_r, high_nxt;
  pin_t                pins_r, pins_nxt;

  phase_t              cur_ph;
  logic [2:0]          cur_step;
  logic [3:0]          cur_bc;
  logic                stop_end;
  logic                start_end;
  logic                byte_sent;
  logic                ack_tick;
  logic                ack_ok;
  logic                is_write;
  logic [7:0]          rd_shift;
  logic [BYTES_W-1:0]  bl_dec;
  logic                word_valid;
  logic                word_last;
  logic                done;
  logic                fail;

  // A request in idle starts the stop sequence on this same tick.
  always_comb begin
    if (phase_r == PH_IDLE && req_type) begin
      cur_ph   = PH_STOP1;
      cur_step = '0;
      cur_bc   = '0;
    end else begin
      cur_ph   = phase_r;
      cur_step = step_r;
      cur_bc   = bit_cnt_r;
    end
  end

  assign stop_end  = cur_step >= 3'd3;
  assign start_end = cur_step >= 3'd4;
  assign byte_sent = cur_bc >= 4'd8;
  assign ack_tick  = byte_sent && (cur_step != 3'd0);
  assign ack_ok    = !sda_in;
  assign is_write  = (cur_ph == PH_WA) || (cur_ph == PH_WP) || (cur_ph == PH_WR);
  assign rd_shift  = {shift_r[6:0], sda_in};
  assign bl_dec    = bytes_left_r - BYTES_W'(1);

  always_comb begin
    phase_nxt = cur_ph;
    unique case (cur_ph)
      PH_IDLE:   phase_nxt = PH_IDLE;
      PH_STOP1:  if (stop_end) phase_nxt = PH_SSEL;
      PH_SSEL:   if (start_end) phase_nxt = PH_WA;
      PH_DELAY:  phase_nxt = PH_SSEL;
      PH_RSTART: if (start_end) phase_nxt = PH_WR;
      PH_WA, PH_WP, PH_WR: begin
        if (ack_tick) begin
          if (ack_ok) begin
            if (cur_ph == PH_WA) begin
              phase_nxt = PH_WP;
            end else if (cur_ph == PH_WP) begin
              phase_nxt = PH_RSTART;
            end else begin
              phase_nxt = PH_RD;
            end
          end else if (cur_ph == PH_WA && attempts_r != 4'd0) begin
            phase_nxt = PH_DELAY;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_RD: begin
        if (byte_sent && cur_step >= 3'd2 && bytes_left_r == '0) begin
          phase_nxt = PH_STOP2;
        end
      end
      PH_STOP2:  if (stop_end) phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    step_nxt       = cur_step;
    bit_cnt_nxt    = cur_bc;
    bytes_left_nxt = bytes_left_r;
    attempts_nxt   = attempts_r;
    shift_nxt      = shift_r;
    high_nxt       = high_r;
    pins_nxt       = pins_r;
    word_valid     = 1'b0;
    word_last      = 1'b0;
    done           = 1'b0;
    fail           = 1'b0;
    case (cur_ph)
      PH_STOP1, PH_STOP2: begin
        case (cur_step)
          3'd0: begin
            pins_nxt.scl = 1'b0;
            pins_nxt.drv = 1'b1;
          end
          3'd1:    pins_nxt.sda = 1'b0;
          3'd2:    pins_nxt.scl = 1'b1;
          default: pins_nxt.sda = 1'b1;
        endcase
        if (stop_end) begin
          step_nxt = '0;
          if (cur_ph == PH_STOP1) begin
            attempts_nxt = (cfg.retry_limit == 4'd0) ? 4'd0 : cfg.retry_limit - 4'd1;
          end else begin
            done = 1'b1;
          end
        end else begin
          step_nxt = cur_step + 3'd1;
        end
      end
      PH_SSEL, PH_RSTART: begin
        case (cur_step)
          3'd0: begin
            pins_nxt.scl = 1'b0;
            pins_nxt.drv = 1'b1;
          end
          3'd1:    pins_nxt.sda = 1'b1;
          3'd2:    pins_nxt.scl = 1'b1;
          3'd3:    pins_nxt.sda = 1'b0;
          default: pins_nxt.scl = 1'b0;
        endcase
        if (start_end) begin
          step_nxt    = '0;
          bit_cnt_nxt = '0;
          shift_nxt   = (cur_ph == PH_SSEL) ? cfg.address_byte
                                            : (cfg.address_byte | cfg.read_mask);
        end else begin
          step_nxt = cur_step + 3'd1;
        end
      end
      PH_DELAY: step_nxt = '0;
      PH_RD: begin
        if (!byte_sent) begin
          if (cur_step == 3'd0) begin
            pins_nxt.drv = 1'b0;
            pins_nxt.scl = 1'b1;
            step_nxt     = 3'd1;
          end else begin
            shift_nxt    = rd_shift;
            pins_nxt.scl = 1'b0;
            step_nxt     = '0;
            bit_cnt_nxt  = cur_bc + 4'd1;
            if (cur_bc == 4'd7) begin
              bytes_left_nxt = bl_dec;
              if (bl_dec[0]) begin
                high_nxt = rd_shift;
              end else begin
                word_valid = 1'b1;
                word_last  = (bl_dec == '0);
              end
            end
          end
        end else if (cur_step == 3'd0) begin
          pins_nxt.drv = 1'b1;
          pins_nxt.sda = (bytes_left_r == '0);
          step_nxt     = 3'd1;
        end else if (cur_step == 3'd1) begin
          pins_nxt.scl = 1'b1;
          step_nxt     = 3'd2;
        end else begin
          pins_nxt.scl = 1'b0;
          step_nxt     = '0;
          bit_cnt_nxt  = '0;
        end
      end
      default: begin
        if (is_write) begin
          if (!byte_sent) begin
            if (cur_step == 3'd0) begin
              pins_nxt.sda = shift_r[7];
              pins_nxt.drv = 1'b1;
              step_nxt     = 3'd1;
            end else if (cur_step == 3'd1) begin
              pins_nxt.scl = 1'b1;
              step_nxt     = 3'd2;
            end else begin
              pins_nxt.scl = 1'b0;
              shift_nxt    = {shift_r[6:0], 1'b0};
              bit_cnt_nxt  = cur_bc + 4'd1;
              step_nxt     = '0;
            end
          end else if (cur_step == 3'd0) begin
            pins_nxt.drv = 1'b0;
            pins_nxt.scl = 1'b1;
            step_nxt     = 3'd1;
          end else begin
            pins_nxt.scl = 1'b0;
            step_nxt     = '0;
            bit_cnt_nxt  = '0;
            if (ack_ok) begin
              if (cur_ph == PH_WA) begin
                shift_nxt = '0;
              end else if (cur_ph == PH_WR) begin
                bytes_left_nxt = READ_BYTES;
              end
            end else if (cur_ph == PH_WA && attempts_r != 4'd0) begin
              attempts_nxt = attempts_r - 4'd1;
            end else begin
              done = 1'b1;
              fail = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    res.pins       = pins_nxt;
    res.word_valid = word_valid;
    res.word_value = word_valid ? {high_r, rd_shift} : 16'd0;
    res.word_last  = word_last;
    res.done_res   = done;
    res.status     = fail;
    res.busy_res   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      step_r       <= '0;
      bit_cnt_r    <= '0;
      bytes_left_r <= '0;
      attempts_r   <= '0;
      shift_r      <= '0;
      high_r       <= '0;
      pins_r       <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      attempts_r   <= attempts_nxt;
      shift_r      <= shift_nxt;
      high_r       <= high_nxt;
      pins_r       <= pins_nxt;
    end
  end

endmodule

@@ rtl/i2c_master_adc_word_reader.sv @@
// Pin-level I2C master that reads the result buffer of a converter.
// Every request on the in_ channel is one bus timing tick: in_tuser set starts a
// buffer read when the block is idle, and in_tdata carries the sampled SDA level.
// Every accepted request produces exactly one result on the out_ channel with
// the SCL, SDA and SDA drive levels after that tick's pin step, plus a word
// flag, the received word, a last-word mark, done, status and busy.
// The result of a request is registered and is in the output register in
// the cycle after acceptance. Throughput is one request per clock cycle while
// results are taken; the pin step logic is combinational, one step per request.
// A new request is taken while the previous result is being taken, so a
// receiver that takes every result keeps the block at full rate. When the
// receiver stalls, the result holds in the output register and in_tready
// drops until it is taken.
// The cfg_ port writes the device address, the read mask and the retry limit;
// write it only while no read is running.
// Reset is synchronous: the pins return to SCL high, SDA high and driven,
// the core and config registers to their defaults; the output register empties.
module i2c_master_adc_word_reader (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] sda_in, [7:1] zero
  input  logic [i2cr_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [18:3] word_value,
  // [19] done_res, [20] status, [21] busy_res, [23:22] zero
  output logic [i2cr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] word_valid
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [i2cr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [i2cr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cr_pkg::*;

  cfg_t  cfg_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_byte <= 8'h00;
      cfg_r.read_mask    <= 8'h01;
      cfg_r.retry_limit  <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ADDRESS_BYTE: cfg_r.address_byte <= cfg_wdata;
        CFG_READ_MASK:    cfg_r.read_mask    <= cfg_wdata;
        CFG_RETRY_LIMIT:  cfg_r.retry_limit  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  i2cr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .req_type (in_tuser),
    .sda_in   (in_tdata[0]),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.busy_res, res_r.status, res_r.done_res,
                       res_r.word_value, res_r.pins.drv, res_r.pins.sda, res_r.pins.scl};
  assign out_tuser  = res_r.word_valid;
  assign out_tlast  = res_r.word_last;

endmodule

@@ rtl/i2cr_checker.sv @@
module i2cr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [i2cr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import i2cr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_last_is_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last mark without a word");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[18:3] == 16'd0 && !out_tlast)
    else $error("word value without word flag");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tdata[19] && !out_tdata[21])
    else $error("failure status outside done");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] && !out_tdata[20] |-> out_tdata[2:0] == 3'b111)
    else $error("successful end without a released bus");

endmodule

bind i2c_master_adc_word_reader i2cr_checker u_i2cr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import i2cr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 36;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  i2c_master_adc_word_reader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Bus master shadow state.
  phase_t     bus_phase;
  logic [2:0] bus_step;
  logic [3:0] bus_bits;
  logic [5:0] bus_bytes_left;
  logic [3:0] bus_tries_left;
  logic [7:0] bus_shift;
  logic [7:0] bus_high;
  pin_t       bus_pins;
  logic [7:0] dev_address;
  logic [7:0] dev_read_mask;
  logic [3:0] dev_retries;

  // Slave behavior used to pick the sampled SDA level.
  int  select_nacks   = 0;
  bit  pointer_nack   = 0;
  bit  read_addr_nack = 0;
  int  data_mode      = 0;
  int  busy_req_pct   = 0;
  bit  no_idle        = 0;

  res_t pending_results[$];
  int   fail_count  = 0;
  int   ticks_sent  = 0;
  int   cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void reset_bus_model();
    dev_address    = 8'h00;
    dev_read_mask  = 8'h01;
    dev_retries    = 4'd3;
    bus_phase      = PH_IDLE;
    bus_step       = '0;
    bus_bits       = '0;
    bus_bytes_left = '0;
    bus_tries_left = '0;
    bus_shift      = '0;
    bus_high       = '0;
    bus_pins       = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
  endfunction

  function automatic bit stop_pin_step();
    bit fin;
    fin = 1'b0;
    case (bus_step)
      3'd0: begin
        bus_pins.scl = 1'b0;
        bus_pins.drv = 1'b1;
      end
      3'd1: bus_pins.sda = 1'b0;
      3'd2: bus_pins.scl = 1'b1;
      default: begin
        bus_pins.sda = 1'b1;
        fin = 1'b1;
      end
    endcase
    bus_step = fin ? 3'd0 : bus_step + 3'd1;
    return fin;
  endfunction

  function automatic bit start_pin_step();
    bit fin;
    fin = 1'b0;
    case (bus_step)
      3'd0: begin
        bus_pins.scl = 1'b0;
        bus_pins.drv = 1'b1;
      end
      3'd1: bus_pins.sda = 1'b1;
      3'd2: bus_pins.scl = 1'b1;
      3'd3: bus_pins.sda = 1'b0;
      default: begin
        bus_pins.scl = 1'b0;
        fin = 1'b1;
      end
    endcase
    bus_step = fin ? 3'd0 : bus_step + 3'd1;
    return fin;
  endfunction

  // Returns 0 while the byte is in flight, 1 on ACK and 2 on NACK.
  function automatic int write_byte_step(bit sda);
    if (bus_bits < 4'd8) begin
      if (bus_step == 3'd0) begin
        bus_pins.sda = bus_shift[7];
        bus_pins.drv = 1'b1;
        bus_step = 3'd1;
      end else if (bus_step == 3'd1) begin
        bus_pins.scl = 1'b1;
        bus_step = 3'd2;
      end else begin
        bus_pins.scl = 1'b0;
        bus_shift = bus_shift << 1;
        bus_bits = bus_bits + 4'd1;
        bus_step = 3'd0;
      end
      return 0;
    end
    if (bus_step == 3'd0) begin
      bus_pins.drv = 1'b0;
      bus_pins.scl = 1'b1;
      bus_step = 3'd1;
      return 0;
    end
    bus_pins.scl = 1'b0;
    bus_step = 3'd0;
    bus_bits = '0;
    return sda ? 2 : 1;
  endfunction

  function automatic void read_byte_step(bit sda, inout res_t r);
    if (bus_bits < 4'd8) begin
      if (bus_step == 3'd0) begin
        bus_pins.drv = 1'b0;
        bus_pins.scl = 1'b1;
        bus_step = 3'd1;
      end else begin
        bus_shift = {bus_shift[6:0], sda};
        bus_pins.scl = 1'b0;
        bus_step = 3'd0;
        bus_bits = bus_bits + 4'd1;
        if (bus_bits == 4'd8) begin
          bus_bytes_left = bus_bytes_left - 6'd1;
          if (bus_bytes_left[0]) begin
            bus_high = bus_shift;
          end else begin
            r.word_valid = 1'b1;
            r.word_value = {bus_high, bus_shift};
            r.word_last  = (bus_bytes_left == '0);
          end
        end
      end
    end else if (bus_step == 3'd0) begin
      bus_pins.drv = 1'b1;
      bus_pins.sda = (bus_bytes_left == '0);
      bus_step = 3'd1;
    end else if (bus_step == 3'd1) begin
      bus_pins.scl = 1'b1;
      bus_step = 3'd2;
    end else begin
      bus_pins.scl = 1'b0;
      bus_step = 3'd0;
      bus_bits = '0;
      if (bus_bytes_left == '0) bus_phase = PH_STOP2;
    end
  endfunction

  function automatic res_t bus_tick_result(bit req, bit sda);
    res_t r;
    int   ack;
    r = '0;
    if (bus_phase == PH_IDLE && req) begin
      bus_phase = PH_STOP1;
      bus_step  = '0;
      bus_bits  = '0;
    end
    case (bus_phase)
      PH_STOP1: begin
        if (stop_pin_step()) begin
          bus_phase = PH_SSEL;
          bus_tries_left = (dev_retries == '0) ? 4'd0 : dev_retries - 4'd1;
        end
      end
      PH_SSEL: begin
        if (start_pin_step()) begin
          bus_phase = PH_WA;
          bus_shift = dev_address;
          bus_bits  = '0;
        end
      end
      PH_DELAY: begin
        bus_phase = PH_SSEL;
        bus_step  = '0;
      end
      PH_RSTART: begin
        if (start_pin_step()) begin
          bus_phase = PH_WR;
          bus_shift = dev_address | dev_read_mask;
          bus_bits  = '0;
        end
      end
      PH_WA, PH_WP, PH_WR: begin
        ack = write_byte_step(sda);
        if (ack == 1) begin
          if (bus_phase == PH_WA) begin
            bus_phase = PH_WP;
            bus_shift = '0;
          end else if (bus_phase == PH_WP) begin
            bus_phase = PH_RSTART;
          end else begin
            bus_phase = PH_RD;
            bus_bytes_left = READ_BYTES;
          end
        end else if (ack == 2) begin
          if (bus_phase == PH_WA && bus_tries_left > 0) begin
            bus_tries_left = bus_tries_left - 4'd1;
            bus_phase = PH_DELAY;
          end else begin
            bus_phase  = PH_IDLE;
            r.done_res = 1'b1;
            r.status   = 1'b1;
          end
        end
      end
      PH_RD: read_byte_step(sda, r);
      PH_STOP2: begin
        if (stop_pin_step()) begin
          bus_phase  = PH_IDLE;
          r.done_res = 1'b1;
        end
      end
      default: bus_phase = PH_IDLE;
    endcase
    r.pins     = bus_pins;
    r.busy_res = (bus_phase != PH_IDLE);
    return r;
  endfunction

  // Chooses what the slave puts on SDA for the next tick.
  function automatic bit slave_sda();
    bit b;
    if ((bus_phase == PH_WA || bus_phase == PH_WP || bus_phase == PH_WR) &&
        bus_bits == 4'd8 && bus_step != 3'd0) begin
      case (bus_phase)
        PH_WA: begin
          b = (select_nacks > 0);
          if (b) select_nacks--;
        end
        PH_WP:   b = pointer_nack;
        default: b = read_addr_nack;
      endcase
    end else if (data_mode == 1) begin
      b = 1'b1;
    end else if (data_mode == 2) begin
      b = 1'b0;
    end else begin
      b = 1'($urandom_range(0, 1));
    end
    return b;
  endfunction

  task automatic send_tick(bit req, bit sda);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(sda);
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(bus_tick_result(req, sda));
    ticks_sent++;
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] addr, logic [7:0] mask, logic [3:0] retries);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ADDRESS_BYTE;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_addr  <= CFG_READ_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_addr  <= CFG_RETRY_LIMIT;
    cfg_wdata <= CFG_DATA_W'(retries);
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_address   = addr;
    dev_read_mask = mask;
    dev_retries   = retries;
  endtask

  task automatic run_read(int nacks, bit ptr_n, bit rd_n);
    select_nacks   = nacks;
    pointer_nack   = ptr_n;
    read_addr_nack = rd_n;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (bus_phase != PH_IDLE) begin
      send_tick($urandom_range(0, 99) < busy_req_pct, slave_sda());
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_select_failure();
    run_read(3, 1'b0, 1'b0);
  endtask

  task automatic test_zero_retry();
    set_config(8'hFF, 8'h00, 4'd0);
    run_read(1, 1'b0, 1'b0);
  endtask

  task automatic test_pointer_nack();
    set_config(8'hA5, 8'h5A, 4'd15);
    run_read(2, 1'b1, 1'b0);
  endtask

  task automatic test_read_address_nack();
    set_config(8'h3C, 8'hFF, 4'd1);
    run_read(0, 1'b0, 1'b1);
  endtask

  task automatic test_full_reads();
    set_config(8'h00, 8'hFF, 4'd1);
    data_mode = 1;
    run_read(0, 1'b0, 1'b0);
    set_config(8'hFF, 8'h00, 4'd2);
    data_mode = 2;
    run_read(1, 1'b0, 1'b0);
    data_mode = 0;
  endtask

  task automatic test_requests_while_busy();
    busy_req_pct = 100;
    run_read(0, 1'b1, 1'b0);
    busy_req_pct = 0;
  endtask

  task automatic test_random_reads();
    int eff_retries;
    int n;
    int reads;
    reads = 0;
    busy_req_pct = 5;
    while (ticks_sent < 900) begin
      if ($urandom_range(0, 99) < 40) begin
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(1, 15)));
      end
      no_idle = (reads == 0);
      repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      eff_retries = (dev_retries == '0) ? 1 : int'(dev_retries);
      if ($urandom_range(0, 99) < 20) n = eff_retries;
      else n = $urandom_range(0, eff_retries - 1);
      run_read(n, $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 10);
      reads++;
    end
    no_idle = 1'b0;
    busy_req_pct = 0;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("scl_level", int'(want.pins.scl), int'(out_tdata[0]));
        check_field("sda_level", int'(want.pins.sda), int'(out_tdata[1]));
        check_field("sda_drive_enable", int'(want.pins.drv), int'(out_tdata[2]));
        check_field("word_valid", int'(want.word_valid), int'(out_tuser));
        check_field("word_value", int'(want.word_value), int'(out_tdata[18:3]));
        check_field("word_last", int'(want.word_last), int'(out_tlast));
        check_field("done_res", int'(want.done_res), int'(out_tdata[19]));
        check_field("status", int'(want.status), int'(out_tdata[20]));
        check_field("busy_res", int'(want.busy_res), int'(out_tdata[21]));
      end
    end
  end

  initial begin
    reset_bus_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_select_failure();
    test_zero_retry();
    test_pointer_nack();
    test_read_address_nack();
    test_full_reads();
    test_requests_while_busy();
    test_random_reads();
    wait_results_drained();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/i2cr_pkg.sv
rtl/i2cr_core.sv
rtl/i2c_master_adc_word_reader.sv
rtl/i2cr_checker.sv
tb/tb.sv
